[rtl/core/obd_pkg.sv]
// Shared types and constants of the energy onset beat detector.
// No dependencies.
package obd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HOP_CFG_W  = 11;
    localparam int WIN_CFG_W  = 7;
    localparam int MBI_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_W      = 24;
    localparam int WIN_MIN    = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HOP          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

    localparam logic [HOP_CFG_W-1:0] HOP_RESET = 11'd480;
    localparam logic [WIN_CFG_W-1:0] WIN_RESET = 7'd16;
    localparam logic [MBI_W-1:0]     MBI_RESET = 10'd15;

    typedef enum logic [2:0] {
        F_IDLE, F_ACC, F_HALF, F_DIFF, F_DEC, F_TAIL, F_FLUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_SWEEP, B_LAST, B_MUL, B_CMP, B_POS, B_OUT, B_END
    } t_bstate;

    typedef struct packed {
        logic             beat_valid;
        logic [OUT_W-1:0] beat_position;
        logic             end_of_buffer;
        logic [OUT_W-1:0] beats_in_buffer;
    } t_result;

endpackage

[rtl/core/obd_fifo.sv]
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH is a power of two.
module obd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // store word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

[rtl/core/obd_front.sv]
// Front end: squares samples, builds half-frame and frame energies, writes
// rises to the ring and issues decide and end commands. Uses obd_pkg.
module obd_front import obd_pkg::*; #(
    parameter int MAX_HOP       = 1024,
    parameter int MAX_WINDOW    = 64,
    parameter int POSITION_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic signed [SAMPLE_W-1:0]           i_sample,
    input  logic                                 i_last,
    input  logic [$clog2(MAX_HOP+1)-1:0]         i_hop,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      i_half_win,
    output logic                                 o_idle,
    output logic                                 o_wr_en,
    output logic [$clog2(MAX_WINDOW)-1:0]        o_wr_addr,
    output logic [32+$clog2(MAX_HOP)-1:0]        o_wr_data,
    output logic                                 o_cmd_push,
    output logic [2*POSITION_BITS:0]             o_cmd_data,
    input  logic                                 i_cmd_full
);
    localparam int HOP_W  = $clog2(MAX_HOP+1);
    localparam int HALF_W = 31 + $clog2(MAX_HOP);
    localparam int DIFF_W = HALF_W + 1;
    localparam int RA_W   = $clog2(MAX_WINDOW);
    localparam int IW     = POSITION_BITS;

    t_fstate                   r_state, n_state;
    logic [30:0]               r_sq;
    logic                      r_last;
    logic [HALF_W-1:0]         r_half, r_prev_half;
    logic [HOP_W-1:0]          r_hcnt;
    logic [1:0]                r_fi;
    logic                      r_do_diff;
    logic [DIFF_W-1:0]         r_energy, r_prev_e;
    logic [IW-1:0]             r_dc, r_dn;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic                      dec_cond, flush_cond, half_done;

    assign sq         = i_sample * i_sample;
    assign half_done  = ((r_hcnt + 1'b1) >= i_hop);
    assign dec_cond   = (({1'b0, r_dn} + (IW+1)'(i_half_win)) <= {1'b0, r_dc})
                     && (({1'b0, r_dn} + (IW+1)'(2)) <= {1'b0, r_dc});
    assign flush_cond = (({1'b0, r_dn} + (IW+1)'(2)) <= {1'b0, r_dc});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_accept) n_state = F_ACC;
            F_ACC:   n_state = half_done ? F_HALF : F_TAIL;
            F_HALF:  n_state = (r_fi != 2'd0) ? F_DIFF : F_TAIL;
            F_DIFF:  n_state = r_do_diff ? F_DEC : F_TAIL;
            F_DEC:   if (!dec_cond) n_state = F_TAIL;
            F_TAIL:  n_state = r_last ? F_FLUSH : F_IDLE;
            F_FLUSH: if (!i_cmd_full && !flush_cond) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle     = (r_state == F_IDLE);
        o_wr_en    = (r_state == F_DIFF) && r_do_diff;
        o_wr_addr  = r_dc[RA_W-1:0];
        o_wr_data  = (r_energy > r_prev_e) ? (r_energy - r_prev_e) : '0;
        o_cmd_push = 1'b0;
        case (r_state)
            F_DEC:   o_cmd_push = dec_cond && !i_cmd_full;
            F_FLUSH: o_cmd_push = !i_cmd_full;
            default: o_cmd_push = 1'b0;
        endcase
        o_cmd_data = {(r_state == F_FLUSH) && !flush_cond, r_dn, r_dc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // energy datapath and command counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= '0;
            r_prev_half <= '0;
            r_hcnt      <= '0;
            r_fi        <= '0;
            r_prev_e    <= '0;
            r_dc        <= '0;
            r_dn        <= IW'(1);
            r_last      <= 1'b0;
            r_do_diff   <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_accept) begin
                        r_sq   <= 31'(sq);
                        r_last <= i_last;
                    end
                end
                F_ACC: begin
                    r_half <= r_half + HALF_W'(r_sq);
                    r_hcnt <= r_hcnt + 1'b1;
                end
                F_HALF: begin
                    r_energy    <= DIFF_W'(r_prev_half) + DIFF_W'(r_half);
                    r_prev_half <= r_half;
                    r_half      <= '0;
                    r_hcnt      <= '0;
                    r_do_diff   <= (r_fi == 2'd2);
                    if (r_fi != 2'd2) r_fi <= r_fi + 1'b1;
                end
                F_DIFF: begin
                    r_prev_e <= r_energy;
                    if (r_do_diff) r_dc <= r_dc + 1'b1;
                end
                F_DEC: begin
                    if (dec_cond && !i_cmd_full) r_dn <= r_dn + 1'b1;
                end
                F_FLUSH: begin
                    if (!i_cmd_full) begin
                        if (flush_cond) begin
                            r_dn <= r_dn + 1'b1;
                        end else begin
                            // drop buffer state after the end command
                            r_half      <= '0;
                            r_prev_half <= '0;
                            r_hcnt      <= '0;
                            r_fi        <= '0;
                            r_prev_e    <= '0;
                            r_dc        <= '0;
                            r_dn        <= IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/obd_back.sv]
// Back end: holds the rise ring, sums the centred window per decide command,
// applies threshold, peak and interval tests and emits result words. Uses obd_pkg.
module obd_back import obd_pkg::*; #(
    parameter int MAX_HOP       = 1024,
    parameter int MAX_WINDOW    = 64,
    parameter int POSITION_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_wr_addr,
    input  logic [32+$clog2(MAX_HOP)-1:0]        i_wr_data,
    input  logic                                 i_cmd_empty,
    input  logic [2*POSITION_BITS:0]             i_cmd_data,
    output logic                                 o_cmd_pop,
    input  logic [$clog2(MAX_HOP+1)-1:0]         i_hop,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      i_half_win,
    input  logic [MBI_W-1:0]                     i_min_int,
    output logic                                 o_res_push,
    output t_result                              o_res_data,
    input  logic                                 i_res_full,
    output logic                                 o_busy
);
    localparam int DIFF_W = 32 + $clog2(MAX_HOP);
    localparam int RA_W   = $clog2(MAX_WINDOW);
    localparam int RING_D = 1 << RA_W;
    localparam int CNT_W  = $clog2(MAX_WINDOW+1);
    localparam int WS_W   = DIFF_W + RA_W;
    localparam int CMP_W  = WS_W + CNT_W + 2;
    localparam int IW     = POSITION_BITS;

    logic [DIFF_W-1:0]  r_ring [RING_D];
    logic [DIFF_W-1:0]  r_rd_data;
    t_bstate            r_state, n_state;
    logic [IW-1:0]      r_i, r_j, r_hi, r_rj, r_lastb, r_pos;
    logic [CNT_W-1:0]   r_cnt;
    logic [WS_W-1:0]    r_ws;
    logic               r_rv, r_seen;
    logic [DIFF_W-1:0]  r_d, r_dm, r_dp;
    logic [CMP_W-1:0]   r_lhs, r_rhs;
    logic [OUT_W-1:0]   r_total;
    logic               cmd_end, beat_ok;
    logic [IW-1:0]      cmd_i, cmd_dc, lo;
    logic [IW:0]        hi_raw, hi;
    logic [DIFF_W+CNT_W:0] prod;

    assign cmd_end = i_cmd_data[2*IW];
    assign cmd_i   = i_cmd_data[2*IW-1:IW];
    assign cmd_dc  = i_cmd_data[IW-1:0];
    assign lo      = (cmd_i > IW'(i_half_win)) ? (cmd_i - IW'(i_half_win)) : '0;
    assign hi_raw  = {1'b0, cmd_i} + (IW+1)'(i_half_win);
    assign hi      = (hi_raw > {1'b0, cmd_dc}) ? {1'b0, cmd_dc} : hi_raw;
    assign prod    = r_d * {r_cnt, 1'b0};
    assign beat_ok = (r_lhs > r_rhs) && (r_d > r_dm) && (r_d >= r_dp)
                  && (!r_seen || ((r_i - r_lastb) >= IW'(i_min_int)));

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_ring[i_wr_addr] <= i_wr_data;
        r_rd_data <= r_ring[r_j[RA_W-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_cmd_empty) n_state = cmd_end ? B_END : B_SWEEP;
            B_SWEEP: if ((r_j + 1'b1) == r_hi) n_state = B_LAST;
            B_LAST:  n_state = B_MUL;
            B_MUL:   n_state = B_CMP;
            B_CMP:   n_state = beat_ok ? B_POS : B_IDLE;
            B_POS:   n_state = B_OUT;
            B_OUT:   if (!i_res_full) n_state = B_IDLE;
            B_END:   if (!i_res_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy     = (r_state != B_IDLE);
        o_cmd_pop  = (r_state == B_IDLE) && !i_cmd_empty;
        o_res_push = 1'b0;
        o_res_data = '0;
        case (r_state)
            B_OUT: begin
                o_res_push               = !i_res_full;
                o_res_data.beat_valid    = 1'b1;
                o_res_data.beat_position = OUT_W'(r_pos);
            end
            B_END: begin
                o_res_push                 = !i_res_full;
                o_res_data.end_of_buffer   = 1'b1;
                o_res_data.beats_in_buffer = r_total;
            end
            default: o_res_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window sweep, tests and beat bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv    <= 1'b0;
            r_seen  <= 1'b0;
            r_lastb <= '0;
            r_total <= '0;
        end else begin
            r_rv <= (r_state == B_SWEEP);
            r_rj <= r_j;
            if (r_rv) begin
                r_ws <= r_ws + WS_W'(r_rd_data);
                if (r_rj == r_i - 1'b1) r_dm <= r_rd_data;
                if (r_rj == r_i)        r_d  <= r_rd_data;
                if (r_rj == r_i + 1'b1) r_dp <= r_rd_data;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_cmd_empty && !cmd_end) begin
                        r_i   <= cmd_i;
                        r_j   <= lo;
                        r_hi  <= hi[IW-1:0];
                        r_cnt <= CNT_W'(hi[IW-1:0] - lo);
                        r_ws  <= '0;
                    end
                end
                B_SWEEP: r_j <= r_j + 1'b1;
                B_MUL: begin
                    r_lhs <= CMP_W'(prod);
                    r_rhs <= CMP_W'(r_ws) + CMP_W'({r_ws, 1'b0});
                end
                B_CMP: begin
                    if (beat_ok) begin
                        r_seen  <= 1'b1;
                        r_lastb <= r_i;
                        r_total <= r_total + 1'b1;
                    end
                end
                B_POS: r_pos <= IW'((r_i + 1'b1) * IW'(i_hop));
                B_END: begin
                    if (!i_res_full) begin
                        r_seen  <= 1'b0;
                        r_lastb <= '0;
                        r_total <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/energy_onset_beat_detector.sv]
// Top level of the energy onset beat detector: configuration registers,
// front end, command queue, back end, result queue. Uses obd_pkg and submodules.
//
// Channel   Direction  Handshake                 Word
// samples   in         push / full               i_sample, i_last_sample
// results   out        pop / empty               beat and end fields
// config    in         cfg_valid / cfg_ready     i_cfg_index, i_cfg_data
//
// A sample runs accumulate and tail; a half-frame close adds half, maybe diff and decide.
// A decide sweeps its window through the one ring read port, then tests for a beat.
// The last sample flushes the pending decides, then the end word follows.
// full stays high until front end, command queue and back end are all idle.
// A full result queue stalls the back end and, through it, the input side.
// Reset is synchronous; the ring needs no clearing pass.
module energy_onset_beat_detector import obd_pkg::*; #(
    parameter int MAX_HOP       = 1024,
    parameter int MAX_WINDOW    = 64,
    parameter int POSITION_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_beat_valid,
    output logic [OUT_W-1:0]           o_beat_position,
    output logic                       o_end_of_buffer,
    output logic [OUT_W-1:0]           o_beats_in_buffer,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int HOP_W  = $clog2(MAX_HOP+1);
    localparam int DIFF_W = 32 + $clog2(MAX_HOP);
    localparam int RA_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW+1);
    localparam int CMD_W  = 2*POSITION_BITS + 1;
    localparam int RES_W  = $bits(t_result);

    logic [HOP_CFG_W-1:0] r_hop;
    logic [WIN_CFG_W-1:0] r_win;
    logic [MBI_W-1:0]     r_mbi;
    logic [HOP_W-1:0]     hop_used;
    logic [31:0]          win_cl;
    logic [CNT_W-1:0]     half_win;
    logic                 accept, front_idle, back_busy;
    logic                 wr_en;
    logic [RA_W-1:0]      wr_addr;
    logic [DIFF_W-1:0]    wr_data;
    logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_W-1:0]     cmd_in, cmd_out;
    logic                 res_push, res_full;
    t_result              res_in, res_out;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop <= HOP_RESET;
            r_win <= WIN_RESET;
            r_mbi <= MBI_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (i_cfg_index)
                CFG_HOP:          r_hop <= i_cfg_data;
                CFG_WINDOW:       r_win <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_MIN_INTERVAL: r_mbi <= i_cfg_data[MBI_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp hop and window to their ranges
    always_comb begin
        if (r_hop == '0)                       hop_used = HOP_W'(1);
        else if (32'(r_hop) > 32'(MAX_HOP))    hop_used = HOP_W'(MAX_HOP);
        else                                   hop_used = HOP_W'(r_hop);
        if (32'(r_win) < 32'(WIN_MIN))         win_cl = 32'(WIN_MIN);
        else if (32'(r_win) > 32'(MAX_WINDOW)) win_cl = 32'(MAX_WINDOW);
        else                                   win_cl = 32'(r_win);
        half_win = CNT_W'(win_cl >> 1);
    end

    assign full   = !front_idle || !cmd_empty || back_busy;
    assign accept = push && !full;

    obd_front #(
        .MAX_HOP(MAX_HOP), .MAX_WINDOW(MAX_WINDOW), .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_accept(accept), .i_sample(i_sample), .i_last(i_last_sample),
        .i_hop(hop_used), .i_half_win(half_win),
        .o_idle(front_idle),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_cmd_push(cmd_push), .o_cmd_data(cmd_in), .i_cmd_full(cmd_full)
    );

    obd_fifo #(.W(CMD_W), .DEPTH(2)) u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(cmd_push), .i_data(cmd_in), .o_full(cmd_full),
        .i_pop(cmd_pop), .o_data(cmd_out), .o_empty(cmd_empty)
    );

    obd_back #(
        .MAX_HOP(MAX_HOP), .MAX_WINDOW(MAX_WINDOW), .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_cmd_empty(cmd_empty), .i_cmd_data(cmd_out), .o_cmd_pop(cmd_pop),
        .i_hop(hop_used), .i_half_win(half_win), .i_min_int(r_mbi),
        .o_res_push(res_push), .o_res_data(res_in), .i_res_full(res_full),
        .o_busy(back_busy)
    );

    obd_fifo #(.W(RES_W), .DEPTH(4)) u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(res_push), .i_data(res_in), .o_full(res_full),
        .i_pop(pop), .o_data(res_out), .o_empty(empty)
    );

    assign o_beat_valid      = res_out.beat_valid;
    assign o_beat_position   = res_out.beat_position;
    assign o_end_of_buffer   = res_out.end_of_buffer;
    assign o_beats_in_buffer = res_out.beats_in_buffer;
endmodule

[rtl/core/obd_checker.sv]
// Port-level checks of the energy onset beat detector, bound to the top level.
// Uses obd_pkg.
module obd_checker import obd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 o_beat_valid,
    input logic [OUT_W-1:0]     o_beat_position,
    input logic                 o_end_of_buffer,
    input logic [OUT_W-1:0]     o_beats_in_buffer
);
    // come out of reset ready and with nothing queued
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("not idle after reset");

    // every word is either a beat or an end marker
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_beat_valid != o_end_of_buffer))
        else $error("result word kind broken");

    // beat words carry no count
    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_beat_valid) |-> (o_beats_in_buffer == '0))
        else $error("beat word with count");

    // end words carry no position
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_buffer) |-> (o_beat_position == '0))
        else $error("end word with position");
endmodule

bind energy_onset_beat_detector obd_checker u_obd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty),
    .o_beat_valid(o_beat_valid), .o_beat_position(o_beat_position),
    .o_end_of_buffer(o_end_of_buffer), .o_beats_in_buffer(o_beats_in_buffer)
);
